@@ rtl/ufd_pkg.sv @@
package ufd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] bytes_after;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        status;
      logic [2:0]  byte_count;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_ASCII,
      KIND_CONT,
      KIND_BAD,
      KIND_LEAD
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] payload;
      logic [1:0] need;
      logic       short_buf;
      logic       buf_end;
   } item_type;

   localparam logic [7:0]  CONT_LO  = 8'h80;
   localparam logic [7:0]  CONT_HI  = 8'hBF;
   localparam logic [7:0]  BAD_LO   = 8'hF5;
   localparam logic [7:0]  LEAD4_LO = 8'hF0;
   localparam logic [7:0]  LEAD3_LO = 8'hE0;
   localparam logic [20:0] CP_LIMIT = 21'h110000;
   localparam logic [20:0] SURR_LO  = 21'h00D800;
   localparam logic [20:0] SURR_HI  = 21'h00DFFF;

   localparam logic       ST_OK   = 1'b0;
   localparam logic       ST_ERR  = 1'b1;
   localparam logic [2:0] CNT_ERR = 3'd0;
   localparam logic [2:0] CNT_ONE = 3'd1;

endpackage

@@ rtl/ufd_front.sv @@
module ufd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ufd_pkg::req_type  req_data,
   output logic              item_valid,
   output ufd_pkg::item_type item_data,
   input  logic              item_pop
);

   ufd_pkg::item_type item_new;
   ufd_pkg::item_type q_ff [2];
   ufd_pkg::item_type q_in [2];
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic [1:0]        cnt_v;
   logic              take;
   logic              drop;

   // byte classification
   always_comb begin
      item_new           = '0;
      item_new.buf_end   = (req_data.bytes_after == 2'd0);
      if (req_data.data_byte < ufd_pkg::CONT_LO) begin
         item_new.kind    = ufd_pkg::KIND_ASCII;
         item_new.payload = req_data.data_byte[6:0];
      end else if (req_data.data_byte <= ufd_pkg::CONT_HI) begin
         item_new.kind    = ufd_pkg::KIND_CONT;
         item_new.payload = {1'b0, req_data.data_byte[5:0]};
      end else if (req_data.data_byte >= ufd_pkg::BAD_LO) begin
         item_new.kind    = ufd_pkg::KIND_BAD;
      end else begin
         item_new.kind = ufd_pkg::KIND_LEAD;
         if (req_data.data_byte >= ufd_pkg::LEAD4_LO) begin
            item_new.need    = 2'd3;
            item_new.payload = {4'b0, req_data.data_byte[2:0]};
         end else if (req_data.data_byte >= ufd_pkg::LEAD3_LO) begin
            item_new.need    = 2'd2;
            item_new.payload = {3'b0, req_data.data_byte[3:0]};
         end else begin
            item_new.need    = 2'd1;
            item_new.payload = {2'b0, req_data.data_byte[4:0]};
         end
      end
      item_new.short_buf = (req_data.bytes_after < item_new.need);
   end

   assign full       = (cnt_ff == 2'd2);
   assign take       = push && !full;
   assign item_valid = (cnt_ff != 2'd0);
   assign item_data  = q_ff[0];
   assign drop       = item_pop && item_valid;

   always_comb begin
      q_in  = q_ff;
      cnt_v = cnt_ff;
      if (drop) begin
         q_in[0] = q_ff[1];
         cnt_v   = cnt_ff - 2'd1;
      end
      if (take) begin
         q_in[cnt_v[0]] = item_new;
      end
      cnt_in = cnt_v + {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

endmodule

@@ rtl/ufd_back.sv @@
module ufd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  ufd_pkg::item_type item_data,
   output logic              item_pop,
   output logic              empty,
   input  logic              pop,
   output ufd_pkg::rsp_type  rsp_data
);

   logic [20:0]      acc_ff;
   logic [20:0]      acc_in;
   logic [1:0]       pend_ff;
   logic [1:0]       pend_in;
   logic [1:0]       seq_ff;
   logic [1:0]       seq_in;
   logic             skip_ff;
   logic             skip_in;

   ufd_pkg::rsp_type r0;
   ufd_pkg::rsp_type r1;
   logic [1:0]       n_res;
   logic             lead_path;
   logic [20:0]      acc_cat;

   ufd_pkg::rsp_type oq_ff [2];
   ufd_pkg::rsp_type oq_in [2];
   logic [1:0]       ocnt_ff;
   logic [1:0]       ocnt_in;
   logic [1:0]       ocnt_v;
   logic             room;
   logic             go;
   logic             drop;

   // decode step: result count, results and next state for the head item
   always_comb begin
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      seq_in    = seq_ff;
      skip_in   = skip_ff;
      r0        = '0;
      r1        = '0;
      n_res     = 2'd0;
      lead_path = 1'b0;
      acc_cat   = {acc_ff[14:0], item_data.payload[5:0]};

      if (pend_ff != 2'd0) begin
         if (item_data.kind == ufd_pkg::KIND_CONT) begin
            acc_in  = acc_cat;
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               n_res = 2'd1;
               if (acc_cat >= ufd_pkg::CP_LIMIT ||
                   (acc_cat >= ufd_pkg::SURR_LO && acc_cat <= ufd_pkg::SURR_HI)) begin
                  r0.status = ufd_pkg::ST_ERR;
               end else begin
                  r0.code_point = acc_cat;
                  r0.status     = ufd_pkg::ST_OK;
                  r0.byte_count = {1'b0, seq_ff} + 3'd1;
               end
               acc_in = '0;
               seq_in = '0;
            end
         end else begin
            r0.status = ufd_pkg::ST_ERR;
            n_res     = 2'd1;
            pend_in   = '0;
            seq_in    = '0;
            acc_in    = '0;
            lead_path = 1'b1;
         end
      end else if (skip_ff && (item_data.kind == ufd_pkg::KIND_CONT ||
                               item_data.kind == ufd_pkg::KIND_BAD)) begin
         if (item_data.buf_end) begin
            skip_in = 1'b0;
         end
      end else begin
         skip_in   = 1'b0;
         lead_path = 1'b1;
      end

      if (lead_path) begin
         unique case (item_data.kind)
            ufd_pkg::KIND_ASCII: begin
               r1.code_point = {14'b0, item_data.payload};
               r1.status     = ufd_pkg::ST_OK;
               r1.byte_count = ufd_pkg::CNT_ONE;
               n_res         = n_res + 2'd1;
            end
            ufd_pkg::KIND_CONT, ufd_pkg::KIND_BAD: begin
               r1.status  = ufd_pkg::ST_ERR;
               r1.byte_count = ufd_pkg::CNT_ERR;
               skip_in    = !item_data.buf_end;
               n_res      = n_res + 2'd1;
            end
            ufd_pkg::KIND_LEAD: begin
               if (item_data.short_buf) begin
                  r1.status = ufd_pkg::ST_ERR;
                  skip_in   = !item_data.buf_end;
                  n_res     = n_res + 2'd1;
               end else begin
                  acc_in  = {14'b0, item_data.payload};
                  pend_in = item_data.need;
                  seq_in  = item_data.need;
               end
            end
            default: begin
               n_res = n_res;
            end
         endcase
         if (pend_ff == 2'd0) begin
            r0 = r1;
         end
      end

      r0.last_of_run = (n_res == 2'd1);
      r1.last_of_run = 1'b1;
   end

   assign room     = ({1'b0, n_res} <= (3'd2 - {1'b0, ocnt_ff}));
   assign go       = item_valid && room;
   assign item_pop = go;

   assign empty    = (ocnt_ff == 2'd0);
   assign rsp_data = oq_ff[0];
   assign drop     = pop && !empty;

   always_comb begin
      oq_in  = oq_ff;
      ocnt_v = ocnt_ff;
      if (drop) begin
         oq_in[0] = oq_ff[1];
         ocnt_v   = ocnt_ff - 2'd1;
      end
      ocnt_in = ocnt_v;
      if (go) begin
         if (n_res != 2'd0) begin
            oq_in[ocnt_v[0]] = r0;
         end
         if (n_res == 2'd2) begin
            oq_in[1] = r1;
         end
         ocnt_in = ocnt_v + n_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= '0;
         acc_ff  <= '0;
         pend_ff <= '0;
         seq_ff  <= '0;
         skip_ff <= 1'b0;
      end else begin
         ocnt_ff <= ocnt_in;
         if (go) begin
            acc_ff  <= acc_in;
            pend_ff <= pend_in;
            seq_ff  <= seq_in;
            skip_ff <= skip_in;
         end
      end
      oq_ff <= oq_in;
   end

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// path: front item queue, decode step, result queue, then the rsp ports
// one byte per cycle unless stalled; the two-entry result queue moves at most one result per
// cycle out, so a byte with two results holds the decode stage until there is room for both
// reset: synchronous, active high; clears both queues and the decoder state
module utf8_stream_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ufd_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output ufd_pkg::rsp_type rsp_data
);

   logic              item_valid;
   logic              item_pop;
   ufd_pkg::item_type item_data;

   ufd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop)
   );

   ufd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/ufd_checker.sv @@
module ufd_checker (
   input logic             clock,
   input logic             reset,
   input logic             push,
   input logic             full,
   input ufd_pkg::req_type req_data,
   input logic             empty,
   input logic             pop,
   input ufd_pkg::rsp_type rsp_data
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // an error transaction carries no character
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status == ufd_pkg::ST_ERR) |->
         (rsp_data.code_point == '0 && rsp_data.byte_count == ufd_pkg::CNT_ERR))
      else $error("error transaction with nonzero payload");

   // a good character is in range, not a surrogate, 1 to 4 bytes
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status == ufd_pkg::ST_OK) |->
         (rsp_data.byte_count != 3'd0 && rsp_data.byte_count <= 3'd4 &&
          rsp_data.code_point < ufd_pkg::CP_LIMIT &&
          (rsp_data.code_point < ufd_pkg::SURR_LO ||
           rsp_data.code_point > ufd_pkg::SURR_HI)))
      else $error("good character out of range");

   // a waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while waiting");

   logic unused_ok;
   assign unused_ok = push ^ (^req_data);

endmodule

bind utf8_stream_decoder ufd_checker u_ufd_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .req_data (req_data),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

@@ dv/utf8_stream_decoder_checker.sv @@
module utf8_stream_decoder_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  ufd_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  ufd_pkg::rsp_type rsp_data,
   output int               error_total,
   output int               waiting
);

   logic [20:0]      acc_bits;
   logic [1:0]       conts_left;
   logic [1:0]       seq_conts;
   logic             skip_mode;
   ufd_pkg::rsp_type char_q[$];
   ufd_pkg::rsp_type want;

   function automatic logic stray_byte(input logic [7:0] b);
      return (b >= ufd_pkg::CONT_LO && b <= ufd_pkg::CONT_HI) || b >= ufd_pkg::BAD_LO;
   endfunction

   function automatic ufd_pkg::rsp_type char_rsp(input logic [20:0] cp, input logic st,
                                                 input logic [2:0] cnt);
      ufd_pkg::rsp_type r;
      r.code_point  = cp;
      r.status      = st;
      r.byte_count  = cnt;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic predict_chars(input ufd_pkg::req_type r);
      ufd_pkg::rsp_type found[2];
      int               k;
      logic [7:0]       b;
      logic [1:0]       after;
      logic             as_lead;
      logic [20:0]      lead_bits;
      logic [1:0]       need;
      k = 0;
      b = r.data_byte;
      after = r.bytes_after;
      as_lead = 1'b0;
      if (conts_left != 0) begin
         if (b >= ufd_pkg::CONT_LO && b <= ufd_pkg::CONT_HI) begin
            acc_bits = {acc_bits[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 0) begin
               if (acc_bits >= ufd_pkg::CP_LIMIT ||
                   (acc_bits >= ufd_pkg::SURR_LO && acc_bits <= ufd_pkg::SURR_HI))
                  found[k] = char_rsp('0, ufd_pkg::ST_ERR, ufd_pkg::CNT_ERR);
               else
                  found[k] = char_rsp(acc_bits, ufd_pkg::ST_OK,
                                      {1'b0, seq_conts} + ufd_pkg::CNT_ONE);
               k++;
               acc_bits = '0;
               seq_conts = '0;
            end
         end else begin
            // broken sequence: drop it and take this byte as a new lead
            found[k] = char_rsp('0, ufd_pkg::ST_ERR, ufd_pkg::CNT_ERR);
            k++;
            conts_left = '0;
            seq_conts = '0;
            acc_bits = '0;
            as_lead = 1'b1;
         end
      end else if (skip_mode && stray_byte(b)) begin
         if (after == 0)
            skip_mode = 1'b0;
      end else begin
         skip_mode = 1'b0;
         as_lead = 1'b1;
      end
      if (as_lead) begin
         if (b < ufd_pkg::CONT_LO) begin
            found[k] = char_rsp({13'b0, b}, ufd_pkg::ST_OK, ufd_pkg::CNT_ONE);
            k++;
         end else if (stray_byte(b)) begin
            skip_mode = (after != 0);
            found[k] = char_rsp('0, ufd_pkg::ST_ERR, ufd_pkg::CNT_ERR);
            k++;
         end else begin
            if (b >= ufd_pkg::LEAD4_LO) begin
               lead_bits = {18'b0, b[2:0]};
               need = 2'd3;
            end else if (b >= ufd_pkg::LEAD3_LO) begin
               lead_bits = {17'b0, b[3:0]};
               need = 2'd2;
            end else begin
               lead_bits = {16'b0, b[4:0]};
               need = 2'd1;
            end
            if (after < need) begin
               skip_mode = (after != 0);
               found[k] = char_rsp('0, ufd_pkg::ST_ERR, ufd_pkg::CNT_ERR);
               k++;
            end else begin
               acc_bits = lead_bits;
               conts_left = need;
               seq_conts = need;
            end
         end
      end
      if (k > 0)
         found[k-1].last_of_run = 1'b1;
      for (int i = 0; i < k; i++)
         char_q.push_back(found[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         acc_bits = '0;
         conts_left = '0;
         seq_conts = '0;
         skip_mode = 1'b0;
         char_q.delete();
         error_total = 0;
      end else begin
         if (pop && !empty) begin
            if (char_q.size() == 0) begin
               $error("result with nothing pending: code_point %h status %b",
                      rsp_data.code_point, rsp_data.status);
               error_total++;
            end else begin
               want = char_q.pop_front();
               if (rsp_data.code_point !== want.code_point) begin
                  $error("code_point: expected %h, got %h", want.code_point,
                         rsp_data.code_point);
                  error_total++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_data.status);
                  error_total++;
               end
               if (rsp_data.byte_count !== want.byte_count) begin
                  $error("byte_count: expected %0d, got %0d", want.byte_count,
                         rsp_data.byte_count);
                  error_total++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b", want.last_of_run,
                         rsp_data.last_of_run);
                  error_total++;
               end
            end
         end
         if (push && !full)
            predict_chars(req_data);
      end
      waiting = char_q.size();
   end

endmodule

@@ dv/tb_utf8_stream_decoder.sv @@
module tb_utf8_stream_decoder;

   localparam int ITEM_GOAL   = 1300;
   localparam int CALM_FROM   = 1100;
   localparam int HOLD_AT     = 600;
   localparam int HOLD_LEN    = 200;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL        = 8;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             push     = 1'b0;
   logic             pop      = 1'b0;
   logic             calm     = 1'b0;
   ufd_pkg::req_type req_data = '0;
   logic             full;
   logic             empty;
   ufd_pkg::rsp_type rsp_data;
   int               error_total;
   int               waiting;
   int               sent     = 0;
   logic [7:0]       stream_q[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   utf8_stream_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   utf8_stream_decoder_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .error_total (error_total),
      .waiting     (waiting)
   );

   task automatic send_byte(input logic [7:0] b, input logic [1:0] after);
      push <= 1'b1;
      req_data <= '{data_byte: b, bytes_after: after};
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   // one buffer: bytes_after counts what is left in stream_q, capped at 3
   task automatic send_stream();
      int left;
      while (stream_q.size() != 0) begin
         left = stream_q.size() - 1;
         if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         send_byte(stream_q.pop_front(), left > 3 ? 2'd3 : left[1:0]);
      end
   endtask

   task automatic send_run(input logic [63:0] bytes, input int n);
      for (int i = n - 1; i >= 0; i--)
         stream_q.push_back(bytes[8*i +: 8]);
      send_stream();
   endtask

   function automatic logic [7:0] lead_byte(input int len);
      case (len)
         1: return 8'($urandom_range(0, 8'h7F));
         2: return 8'($urandom_range(8'hC0, 8'hDF));
         3: return 8'($urandom_range(8'hE0, 8'hEF));
         default: return 8'($urandom_range(8'hF0, 8'hF4));
      endcase
   endfunction

   // mostly well-formed characters, some noise bytes and cut-off sequences
   task automatic add_char();
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         len = $urandom_range(1, 4);
         stream_q.push_back(lead_byte(len));
         repeat (len - 1) stream_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 9) begin
         stream_q.push_back(8'($urandom_range(0, 8'hFF)));
      end else begin
         len = $urandom_range(2, 4);
         stream_q.push_back(lead_byte(len));
         repeat (len - 2) stream_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
   endtask

   initial begin
      int cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_run(64'h00, 1);
      send_run(64'h7F_C2A9, 3);
      send_run(64'hE282AC, 3);
      send_run(64'hEDA080, 3);
      send_run(64'hF48FBFBF, 4);
      send_run(64'hF4908080, 4);
      send_run(64'hF5BFFF41, 4);
      send_run(64'hE282, 2);
      send_run(64'hC341, 2);
      while (sent < ITEM_GOAL) begin
         if (sent >= CALM_FROM)
            calm <= 1'b1;
         repeat ($urandom_range(1, 8)) add_char();
         send_stream();
      end
      push <= 1'b0;
      cycles = 0;
      do begin
         @(negedge clock);
         cycles++;
      end while (waiting != 0 && cycles < DRAIN_LIMIT);
      repeat (TAIL) @(negedge clock);
      if (error_total == 0 && waiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (waiting != 0)
            $error("%0d characters never came out", waiting);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // receiver: random stall bursts, one long hold-off so the block backs up
   initial begin
      int cyc;
      int hold;
      cyc = 0;
      hold = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == HOLD_AT)
            hold = HOLD_LEN;
         if (hold > 0) begin
            pop <= 1'b0;
            hold--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            hold = $urandom_range(1, 17) - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ufd_pkg.sv
rtl/ufd_front.sv
rtl/ufd_back.sv
rtl/utf8_stream_decoder.sv
rtl/ufd_checker.sv
dv/utf8_stream_decoder_checker.sv
dv/tb_utf8_stream_decoder.sv
